// ===== rtl/pipt_pkg.sv =====
// Shared widths and item codes for the point-in-polygon test unit.
// Used by the channel interfaces and by the top level; depends on nothing.
package pipt_pkg;

    localparam int MODE_W  = 2;
    localparam int COORD_W = 16;
    localparam int TOTAL_W = 6;

    // Item codes carried in the mode field; the fourth code is unused.
    localparam logic [MODE_W-1:0] MODE_CLEAR  = 2'd0;
    localparam logic [MODE_W-1:0] MODE_APPEND = 2'd1;
    localparam logic [MODE_W-1:0] MODE_QUERY  = 2'd2;

endpackage

// ===== rtl/pipt_if.sv =====
// Valid/ready channel interfaces for the point-in-polygon test unit.
// Depends on pipt_pkg for field widths.
interface pipt_req_if;
    logic                                valid;
    logic                                ready;
    logic [pipt_pkg::MODE_W-1:0]         mode;
    logic signed [pipt_pkg::COORD_W-1:0] coord_x;
    logic signed [pipt_pkg::COORD_W-1:0] coord_y;
    logic signed [pipt_pkg::COORD_W-1:0] offset_x;
    logic signed [pipt_pkg::COORD_W-1:0] offset_y;

    modport source (output valid, mode, coord_x, coord_y, offset_x, offset_y, input ready);
    modport sink   (input valid, mode, coord_x, coord_y, offset_x, offset_y, output ready);
endinterface

interface pipt_rsp_if;
    logic                          valid;
    logic                          ready;
    logic                          inside_res;
    logic                          store_full;
    logic [pipt_pkg::TOTAL_W-1:0]  vertex_total;

    modport source (output valid, inside_res, store_full, vertex_total, input ready);
    modport sink   (input valid, inside_res, store_full, vertex_total, output ready);
endinterface

// ===== rtl/point_in_polygon_test_unit.sv =====
// Top level of the even-odd point-in-polygon test unit: vertex memory,
// scan sequencer and edge crossing pipeline. Depends on pipt_pkg and pipt_if.
//
//   channel | direction | fields
//   --------+-----------+--------------------------------------------------
//   req     | sink      | mode, coord_x, coord_y, offset_x, offset_y
//   rsp     | source    | inside_res, store_full, vertex_total
//
// Clear, append, the unused code and a query of an empty polygon give their
// result in the cycle after the request transfer. A query of a polygon with n
// vertices scans the store: the scan reads one vertex per cycle from the
// single read port of the vertex memory (n + 1 reads, the first vertex is read
// again to close the polygon), then the edge pipeline drains.
// Reset clears the vertex count and all control; the memory is not cleared.
// A new request is taken only when the block is idle and the result register
// is empty or being emptied in the same cycle, so a stalled rsp holds req off.
module point_in_polygon_test_unit #(
    parameter int MAX_VERTICES = 32
) (
    input  logic        clk,
    input  logic        rst_n,
    pipt_req_if.sink    req,
    pipt_rsp_if.source  rsp
);

    localparam int AW = (MAX_VERTICES > 1) ? $clog2(MAX_VERTICES) : 1;
    localparam int CW = $clog2(MAX_VERTICES + 1);
    localparam int CRD = pipt_pkg::COORD_W;
    localparam int VW = 2 * CRD;
    localparam int SW = CRD + 1;        // vertex plus offset
    localparam int DW = CRD + 2;        // differences of sums
    localparam int PW = 2 * DW;         // cross products

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_DRAIN
    } state_t;

    state_t state_reg;

    // Control and result registers.
    logic [CW-1:0]              count_reg;
    logic [CW-1:0]              rd_idx_reg;
    logic                       inside_acc_reg;
    logic                       out_valid_reg;
    logic                       out_inside_reg;
    logic                       out_full_reg;
    logic [pipt_pkg::TOTAL_W-1:0] out_total_reg;

    // Query operands, held for the whole scan.
    logic signed [CRD-1:0] qx_reg;
    logic signed [CRD-1:0] qy_reg;
    logic signed [CRD-1:0] ox_reg;
    logic signed [CRD-1:0] oy_reg;

    // Vertex memory, x in the upper half of each word.
    logic [VW-1:0] vtx_mem [MAX_VERTICES];
    logic [VW-1:0] rdata_reg;

    logic          req_xfer;
    logic          rsp_xfer;
    logic          has_room;
    logic          wr_en;
    logic          rd_en;
    logic          rd_last;
    logic [AW-1:0] rd_addr;
    logic          pipe_busy;

    // Edge pipeline.
    logic                 s1_valid_reg;
    logic                 s1_first_reg;
    logic                 s2_valid_reg;
    logic                 s3_valid_reg;
    logic                 s4_valid_reg;
    logic signed [SW-1:0] prev_x_reg;
    logic signed [SW-1:0] prev_y_reg;
    logic signed [SW-1:0] cur_x_reg;
    logic signed [SW-1:0] cur_y_reg;
    logic signed [CRD-1:0] rd_x;
    logic signed [CRD-1:0] rd_y;

    logic signed [SW-1:0] qx_ext;
    logic signed [SW-1:0] qy_ext;
    logic signed [SW-1:0] ylo;
    logic signed [SW-1:0] yhi;
    logic signed [SW-1:0] xhi;
    logic                 in_band;
    logic signed [DW-1:0] dy_next;
    logic signed [DW-1:0] dxq_next;
    logic signed [DW-1:0] dyq_next;
    logic signed [DW-1:0] dbx_next;

    logic                 s3_band_reg;
    logic                 s3_vert_reg;
    logic                 s3_dypos_reg;
    logic signed [DW-1:0] s3_dy_reg;
    logic signed [DW-1:0] s3_dxq_reg;
    logic signed [DW-1:0] s3_dyq_reg;
    logic signed [DW-1:0] s3_dbx_reg;

    logic                 s4_band_reg;
    logic                 s4_vert_reg;
    logic                 s4_dypos_reg;
    logic signed [PW-1:0] s4_lhs_reg;
    logic signed [PW-1:0] s4_rhs_reg;
    logic                 s4_cross;

    assign req_xfer = req.valid && req.ready;
    assign rsp_xfer = rsp.valid && rsp.ready;

    assign req.ready        = (state_reg == ST_IDLE) && (!out_valid_reg || rsp.ready);
    assign rsp.valid        = out_valid_reg;
    assign rsp.inside_res   = out_inside_reg;
    assign rsp.store_full   = out_full_reg;
    assign rsp.vertex_total = out_total_reg;

    assign has_room = (count_reg < CW'(MAX_VERTICES));
    // Appends happen only while idle, so a write never meets a scan read.
    assign wr_en    = req_xfer && (req.mode == pipt_pkg::MODE_APPEND) && has_room;

    // The scan reads entries 0 to n-1 and then entry 0 again for the closing edge.
    assign rd_en     = (state_reg == ST_SCAN);
    assign rd_last   = (rd_idx_reg == count_reg);
    assign rd_addr   = rd_last ? '0 : rd_idx_reg[AW-1:0];
    assign pipe_busy = s1_valid_reg || s2_valid_reg || s3_valid_reg || s4_valid_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            vtx_mem[count_reg[AW-1:0]] <= {req.coord_x, req.coord_y};
        end
        if (rd_en)
        begin
            rdata_reg <= vtx_mem[rd_addr];
        end
    end

    // Sequencer, vertex count and result register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            count_reg      <= '0;
            rd_idx_reg     <= '0;
            inside_acc_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
            out_inside_reg <= 1'b0;
            out_full_reg   <= 1'b0;
            out_total_reg  <= '0;
        end
        else
        begin
            // A request taken in the same cycle sets the result register itself.
            if (rsp_xfer && !req_xfer)
            begin
                out_valid_reg <= 1'b0;
            end
            if (s4_valid_reg && s4_cross)
            begin
                inside_acc_reg <= !inside_acc_reg;
            end
            case (state_reg)
                ST_IDLE:
                begin
                    if (req_xfer)
                    begin
                        out_inside_reg <= 1'b0;
                        case (req.mode)
                            pipt_pkg::MODE_CLEAR:
                            begin
                                count_reg     <= '0;
                                out_valid_reg <= 1'b1;
                                out_full_reg  <= 1'b0;
                                out_total_reg <= '0;
                            end
                            pipt_pkg::MODE_APPEND:
                            begin
                                out_valid_reg <= 1'b1;
                                out_full_reg  <= !has_room;
                                if (has_room)
                                begin
                                    count_reg     <= count_reg + 1'b1;
                                    out_total_reg <= pipt_pkg::TOTAL_W'(count_reg + 1'b1);
                                end
                                else
                                begin
                                    out_total_reg <= pipt_pkg::TOTAL_W'(count_reg);
                                end
                            end
                            pipt_pkg::MODE_QUERY:
                            begin
                                // An empty polygon answers outside at once.
                                if (count_reg != '0)
                                begin
                                    out_valid_reg  <= 1'b0;
                                    state_reg      <= ST_SCAN;
                                    rd_idx_reg     <= '0;
                                    inside_acc_reg <= 1'b0;
                                end
                                else
                                begin
                                    out_valid_reg <= 1'b1;
                                    out_full_reg  <= 1'b0;
                                    out_total_reg <= pipt_pkg::TOTAL_W'(count_reg);
                                end
                            end
                            default:
                            begin
                                // The unused code changes nothing.
                                out_valid_reg <= 1'b1;
                                out_full_reg  <= 1'b0;
                                out_total_reg <= pipt_pkg::TOTAL_W'(count_reg);
                            end
                        endcase
                    end
                end
                ST_SCAN:
                begin
                    rd_idx_reg <= rd_idx_reg + 1'b1;
                    if (rd_last)
                    begin
                        state_reg <= ST_DRAIN;
                    end
                end
                ST_DRAIN:
                begin
                    if (!pipe_busy)
                    begin
                        out_valid_reg  <= 1'b1;
                        out_inside_reg <= inside_acc_reg;
                        out_full_reg   <= 1'b0;
                        out_total_reg  <= pipt_pkg::TOTAL_W'(count_reg);
                        state_reg      <= ST_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        if (req_xfer && (req.mode == pipt_pkg::MODE_QUERY))
        begin
            qx_reg <= req.coord_x;
            qy_reg <= req.coord_y;
            ox_reg <= req.offset_x;
            oy_reg <= req.offset_y;
        end
    end

    // Pipeline valid flags. The first read only primes the previous vertex.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            s1_first_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
            s3_valid_reg <= 1'b0;
            s4_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg <= rd_en;
            s1_first_reg <= rd_en && (rd_idx_reg == '0);
            s2_valid_reg <= s1_valid_reg && !s1_first_reg;
            s3_valid_reg <= s2_valid_reg;
            s4_valid_reg <= s3_valid_reg;
        end
    end

    assign rd_x = $signed(rdata_reg[VW-1:CRD]);
    assign rd_y = $signed(rdata_reg[CRD-1:0]);

    // Stage 2: band test on the edge from the previous to the current vertex,
    // plus the differences for the exact intersection compare.
    always_comb
    begin
        qx_ext   = {qx_reg[CRD-1], qx_reg};
        qy_ext   = {qy_reg[CRD-1], qy_reg};
        ylo      = (prev_y_reg < cur_y_reg) ? prev_y_reg : cur_y_reg;
        yhi      = (prev_y_reg < cur_y_reg) ? cur_y_reg : prev_y_reg;
        xhi      = (prev_x_reg < cur_x_reg) ? cur_x_reg : prev_x_reg;
        in_band  = (qy_ext > ylo) && (qy_ext <= yhi) && (qx_ext <= xhi);
        dy_next  = {cur_y_reg[SW-1], cur_y_reg} - {prev_y_reg[SW-1], prev_y_reg};
        dxq_next = {qx_ext[SW-1], qx_ext} - {prev_x_reg[SW-1], prev_x_reg};
        dyq_next = {qy_ext[SW-1], qy_ext} - {prev_y_reg[SW-1], prev_y_reg};
        dbx_next = {cur_x_reg[SW-1], cur_x_reg} - {prev_x_reg[SW-1], prev_x_reg};
    end

    // Within the band dy is never zero, so its sign bit alone gives dy > 0.
    assign s4_cross = s4_band_reg &&
                      (s4_vert_reg || (s4_dypos_reg ? (s4_lhs_reg <= s4_rhs_reg)
                                                    : (s4_lhs_reg >= s4_rhs_reg)));

    always_ff @(posedge clk)
    begin
        if (s1_valid_reg)
        begin
            prev_x_reg <= cur_x_reg;
            prev_y_reg <= cur_y_reg;
            cur_x_reg  <= {rd_x[CRD-1], rd_x} + {ox_reg[CRD-1], ox_reg};
            cur_y_reg  <= {rd_y[CRD-1], rd_y} + {oy_reg[CRD-1], oy_reg};
        end
        s3_band_reg  <= in_band;
        s3_vert_reg  <= (prev_x_reg == cur_x_reg);
        s3_dypos_reg <= !dy_next[DW-1];
        s3_dy_reg    <= dy_next;
        s3_dxq_reg   <= dxq_next;
        s3_dyq_reg   <= dyq_next;
        s3_dbx_reg   <= dbx_next;

        s4_band_reg  <= s3_band_reg;
        s4_vert_reg  <= s3_vert_reg;
        s4_dypos_reg <= s3_dypos_reg;
        s4_lhs_reg   <= s3_dxq_reg * s3_dy_reg;
        s4_rhs_reg   <= s3_dyq_reg * s3_dbx_reg;
    end

    // The vertex count never passes the store depth.
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CW'(MAX_VERTICES))
        else $error("vertex count above store depth");

    // The memory is written only while no scan is running.
    a_write_idle: assert property (@(posedge clk) disable iff (!rst_n)
        wr_en |-> (state_reg == ST_IDLE) && !pipe_busy)
        else $error("vertex write during a scan");

    // The edge pipeline is empty whenever the sequencer is idle.
    a_pipe_idle: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_IDLE) |-> !pipe_busy)
        else $error("edge pipeline busy while idle");

    // A query of an empty polygon answers outside in the next cycle.
    a_empty_query: assert property (@(posedge clk) disable iff (!rst_n)
        (req_xfer && (req.mode == pipt_pkg::MODE_QUERY) && (count_reg == '0))
        |=> rsp.valid && !rsp.inside_res)
        else $error("empty polygon query not answered outside");

    // A dropped append reports a full store.
    a_full_total: assert property (@(posedge clk) disable iff (!rst_n)
        (rsp.valid && rsp.store_full) |-> (count_reg == CW'(MAX_VERTICES)))
        else $error("store_full with room left");

endmodule
